// ===== sv/generational_handle_table_assert.svh =====
// ---------------------------------------------------------------------------
// Generational handle table: assertion macros
// Concurrent assertion helpers clocked on clk and disabled by rst.
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define GHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GHT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define GHT_ASSERT(lbl, prop, msg)
`define GHT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/ght_pkg.sv =====
// ---------------------------------------------------------------------------
// Generational handle table package
// Field widths, request and status codes, and the beats passed between parts.
// ---------------------------------------------------------------------------
package ght_pkg;

  localparam int REQ_W  = 2;
  localparam int OBJ_W  = 32;
  localparam int ID_W   = 16;
  localparam int GEN_W  = 32;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 11;
  localparam int LIVE_W = 11;

  localparam logic [REQ_W-1:0] REQ_REGISTER   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UNREGISTER = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESOLVE    = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STAT_W-1:0] ST_STATE     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_BUSY      = 3'd4;

  // What the back part has to do with a classified request.
  localparam logic [1:0] KIND_DONE     = 2'd0;  // status already final
  localparam logic [1:0] KIND_REGISTER = 2'd1;
  localparam logic [1:0] KIND_UNREG    = 2'd2;
  localparam logic [1:0] KIND_RESOLVE  = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [STAT_W-1:0] status;
    logic [OBJ_W-1:0]  obj;
    logic [GEN_W-1:0]  gen;
    logic [ID_W-1:0]   idx;    // slot index (id minus one)
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [GEN_W-1:0]  out_gen;
    logic [OBJ_W-1:0]  obj_ref_out;
    logic [LIVE_W-1:0] live_slots;
  } res_t;

endpackage

// ===== sv/ght_fifo.sv =====
// ---------------------------------------------------------------------------
// Generational handle table: small queue
// Register based FIFO with full and empty flags and show-ahead read data.
// ---------------------------------------------------------------------------
module ght_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/ght_front.sv =====
// ---------------------------------------------------------------------------
// Generational handle table: front end
// Holds the capacity register and classifies requests without the table.
// ---------------------------------------------------------------------------
module ght_front #(
  parameter int SLOTS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ght_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       push,
  input  logic [ght_pkg::REQ_W-1:0]  req_type,
  input  logic [ght_pkg::OBJ_W-1:0]  obj_ref,
  input  logic [ght_pkg::ID_W-1:0]   handle_id,
  input  logic [ght_pkg::GEN_W-1:0]  handle_gen,
  input  logic                       cmd_full,
  output ght_pkg::cmd_t              cmd,
  output logic                       cmd_push,
  output logic [((($clog2(SLOTS + 1)) > ght_pkg::CFG_W) ?
                 $clog2(SLOTS + 1) : ght_pkg::CFG_W)-1:0] cap,
  output logic                       rebuild
);

  import ght_pkg::*;

  localparam int PW   = $clog2(SLOTS + 1);
  localparam int CAPW = (PW > CFG_W) ? PW : CFG_W;

  logic [ID_W-1:0] idx;
  logic            in_range;

  // Capacity: a zero write is dropped, larger values saturate to SLOTS.
  assign rebuild = cfg_we && (cfg_data != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAPW'(SLOTS);
    end else if (rebuild) begin
      cap <= (32'(cfg_data) > 32'(SLOTS)) ? CAPW'(SLOTS) : CAPW'(cfg_data);
    end
  end

  assign idx      = handle_id - ID_W'(1);
  assign in_range = (32'(idx) < 32'(cap)) && (32'(idx) < 32'(SLOTS));
  assign cmd_push = push && !cmd_full;

  always_comb begin
    cmd        = '0;
    cmd.obj    = obj_ref;
    cmd.gen    = handle_gen;
    cmd.idx    = idx;
    cmd.kind   = KIND_DONE;
    cmd.status = ST_INVALID;
    case (req_type)
      REQ_REGISTER: begin
        if (obj_ref == '0) begin
          cmd.status = ST_INVALID;
        end else if ((handle_id != '0) && (handle_gen != '0)) begin
          cmd.status = ST_STATE;
        end else begin
          cmd.kind   = KIND_REGISTER;
          cmd.status = ST_OK;
        end
      end
      REQ_UNREGISTER, REQ_RESOLVE: begin
        if ((handle_id == '0) || (handle_gen == '0)) begin
          cmd.status = ST_INVALID;
        end else if (!in_range) begin
          cmd.status = ST_NOT_FOUND;
        end else begin
          cmd.kind   = (req_type == REQ_UNREGISTER) ? KIND_UNREG : KIND_RESOLVE;
          cmd.status = ST_OK;
        end
      end
      default: begin
        cmd.status = ST_INVALID;
      end
    endcase
  end

endmodule

// ===== sv/ght_back.sv =====
// ---------------------------------------------------------------------------
// Generational handle table: back end
// Slot memory, free list and occupancy; one read, up to one write per request.
// ---------------------------------------------------------------------------
`include "generational_handle_table_assert.svh"

module ght_back #(
  parameter int SLOTS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rebuild,
  input  logic [((($clog2(SLOTS + 1)) > ght_pkg::CFG_W) ?
                 $clog2(SLOTS + 1) : ght_pkg::CFG_W)-1:0] cap,
  input  ght_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output ght_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full
);

  import ght_pkg::*;

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW   = $clog2(SLOTS + 1);
  localparam int CAPW = (PW > CFG_W) ? PW : CFG_W;
  localparam logic [PW-1:0] SLOTS_P = PW'(SLOTS);

  localparam logic S_ISSUE = 1'b0;
  localparam logic S_EXEC  = 1'b1;

  logic [OBJ_W-1:0] mem_obj  [SLOTS];
  logic [GEN_W-1:0] mem_gen  [SLOTS];
  logic [PW-1:0]    mem_link [SLOTS];

  logic            state;
  logic [PW-1:0]   head;
  logic [PW-1:0]   head_next;
  logic [PW-1:0]   fill;       // slots at or above fill still hold reset values
  logic [PW-1:0]   fill_next;
  logic [CAPW-1:0] count;
  logic [CAPW-1:0] count_next;

  cmd_t             cmd_q;
  logic [IW-1:0]    addr_q;
  logic             fresh_q;
  logic [OBJ_W-1:0] obj_q;
  logic [GEN_W-1:0] gen_q;
  logic [PW-1:0]    link_q;

  logic [IW-1:0]    raddr;
  logic             start;
  logic [OBJ_W-1:0] eff_obj;
  logic [GEN_W-1:0] eff_gen;
  logic [PW-1:0]    eff_link;
  logic [GEN_W-1:0] gen_inc;
  logic             hit;
  logic             wen;
  logic [OBJ_W-1:0] wobj;
  logic [GEN_W-1:0] wgen;
  logic [PW-1:0]    wlink;

  assign start   = (state == S_ISSUE) && !cmd_empty && !res_full && !rebuild;
  assign cmd_pop = start;
  assign raddr   = (cmd.kind == KIND_REGISTER) ? IW'(head) : IW'(cmd.idx);

  // Read stage
  always_ff @(posedge clk) begin
    obj_q  <= mem_obj[raddr];
    gen_q  <= mem_gen[raddr];
    link_q <= mem_link[raddr];
    if (start) begin
      cmd_q   <= cmd;
      addr_q  <= raddr;
      fresh_q <= (PW'(raddr) >= fill);
    end
  end

  // Write stage
  always_ff @(posedge clk) begin
    if (wen) begin
      mem_obj[addr_q]  <= wobj;
      mem_gen[addr_q]  <= wgen;
      mem_link[addr_q] <= wlink;
    end
  end

  assign eff_obj  = fresh_q ? '0 : obj_q;
  assign eff_gen  = fresh_q ? GEN_W'(1) : gen_q;
  assign eff_link = fresh_q ? (PW'(addr_q) + PW'(1)) : link_q;
  assign gen_inc  = eff_gen + GEN_W'(1);
  assign hit      = (eff_obj != '0) && (eff_gen == cmd_q.gen);

  always_comb begin
    res        = '0;
    res.status = cmd_q.status;
    wen        = 1'b0;
    wobj       = eff_obj;
    wgen       = eff_gen;
    wlink      = eff_link;
    head_next  = head;
    fill_next  = fill;
    count_next = count;
    case (cmd_q.kind)
      KIND_REGISTER: begin
        if ((CAPW'(head) >= cap) || (head >= SLOTS_P)) begin
          res.status = ST_BUSY;
        end else begin
          res.status  = ST_OK;
          res.out_id  = ID_W'(addr_q) + ID_W'(1);
          res.out_gen = eff_gen;
          wen         = 1'b1;
          wobj        = cmd_q.obj;
          head_next   = eff_link;
          count_next  = count + CAPW'(1);
          if (PW'(addr_q) == fill) begin
            fill_next = fill + PW'(1);
          end
        end
      end
      KIND_UNREG: begin
        if (!hit) begin
          res.status = ST_NOT_FOUND;
        end else if (count == '0) begin
          res.status = ST_STATE;
        end else begin
          res.status = ST_OK;
          wen        = 1'b1;
          wobj       = '0;
          wgen       = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
          wlink      = head;
          head_next  = PW'(addr_q);
          count_next = count - CAPW'(1);
        end
      end
      KIND_RESOLVE: begin
        if (!hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.status      = ST_OK;
          res.obj_ref_out = eff_obj;
        end
      end
      default: begin
        res.status = cmd_q.status;
      end
    endcase
    res.live_slots = count_next[LIVE_W-1:0];
    wen            = wen && (state == S_EXEC) && !rebuild;
  end

  assign res_push = (state == S_EXEC) && !rebuild;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ISSUE;
      head  <= '0;
      fill  <= '0;
      count <= '0;
    end else if (rebuild) begin
      state <= S_ISSUE;
      head  <= '0;
      fill  <= '0;
      count <= '0;
    end else begin
      case (state)
        S_ISSUE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          head  <= head_next;
          fill  <= fill_next;
          count <= count_next;
          state <= S_ISSUE;
        end
        default: begin
          state <= S_ISSUE;
        end
      endcase
    end
  end

  `GHT_ASSERT(a_count_le_cap, count <= cap, "occupied count exceeds capacity")
  `GHT_ASSERT(a_head_le_fill, head <= fill, "free-list head beyond written region")
  `GHT_ASSERT(a_fill_bound, fill <= SLOTS_P, "fill count beyond table depth")
  `GHT_ASSERT_IMPL(a_exec_room, state == S_EXEC, !res_full, "result queue full in exec")

endmodule

// ===== sv/generational_handle_table.sv =====
// ---------------------------------------------------------------------------
// Generational handle table (slot map)
// A request beat passes the front end checks and the command queue; the back
// end reads the slot memory, then does any write-back in its exec state before
// it takes the next request. Queues of 2 beats sit on either side.
// Reset (synchronous, rst high): empty table, capacity SLOTS, no clearing pass;
// a fill count stands in for the reset values of slots never written.
// ---------------------------------------------------------------------------
module generational_handle_table #(
  parameter int SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  // capacity register write
  input  logic                        cfg_we,
  input  logic [ght_pkg::CFG_W-1:0]   cfg_data,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic [ght_pkg::REQ_W-1:0]   req_type,
  input  logic [ght_pkg::OBJ_W-1:0]   obj_ref,
  input  logic [ght_pkg::ID_W-1:0]    handle_id,
  input  logic [ght_pkg::GEN_W-1:0]   handle_gen,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic [ght_pkg::STAT_W-1:0]  status,
  output logic [ght_pkg::ID_W-1:0]    out_id,
  output logic [ght_pkg::GEN_W-1:0]   out_gen,
  output logic [ght_pkg::OBJ_W-1:0]   obj_ref_out,
  output logic [ght_pkg::LIVE_W-1:0]  live_slots
);

  import ght_pkg::*;

  localparam int PW    = $clog2(SLOTS + 1);
  localparam int CAPW  = (PW > CFG_W) ? PW : CFG_W;
  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  // Front end: capacity register plus the checks that need no slot data
  // (null reference, handle already valid, zero id or generation, id beyond
  // capacity, unknown request). It writes one classified beat per request.
  cmd_t            front_cmd;
  logic            front_push;
  logic [CAPW-1:0] cap;
  logic            rebuild;

  // Command queue between front and back.
  logic            cmdq_full;
  logic            cmdq_empty;
  logic            cmdq_pop;
  logic [CMD_W-1:0] cmdq_rdata;
  cmd_t            back_cmd;

  // Result queue toward the consumer.
  res_t            back_res;
  logic            res_push;
  logic            resq_full;
  logic [RES_W-1:0] resq_rdata;
  res_t            out_res;

  ght_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .push      (push),
    .req_type  (req_type),
    .obj_ref   (obj_ref),
    .handle_id (handle_id),
    .handle_gen(handle_gen),
    .cmd_full  (cmdq_full),
    .cmd       (front_cmd),
    .cmd_push  (front_push),
    .cap       (cap),
    .rebuild   (rebuild)
  );

  assign full = cmdq_full;

  ght_fifo #(
    .W    (CMD_W),
    .DEPTH(2)
  ) u_cmdq (
    .clk  (clk),
    .rst  (rst),
    .push (front_push),
    .wdata(front_cmd),
    .full (cmdq_full),
    .pop  (cmdq_pop),
    .rdata(cmdq_rdata),
    .empty(cmdq_empty)
  );

  assign back_cmd = cmd_t'(cmdq_rdata);

  // Back end: reads the slot (or the free-list head slot for a register),
  // then resolves the match, updates the free list, writes back a changed slot.
  ght_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .rebuild  (rebuild),
    .cap      (cap),
    .cmd      (back_cmd),
    .cmd_empty(cmdq_empty),
    .cmd_pop  (cmdq_pop),
    .res      (back_res),
    .res_push (res_push),
    .res_full (resq_full)
  );

  ght_fifo #(
    .W    (RES_W),
    .DEPTH(2)
  ) u_resq (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(back_res),
    .full (resq_full),
    .pop  (pop),
    .rdata(resq_rdata),
    .empty(empty)
  );

  // Oldest result beat drives the ports while empty is low.
  assign out_res     = res_t'(resq_rdata);
  assign status      = out_res.status;
  assign out_id      = out_res.out_id;
  assign out_gen     = out_res.out_gen;
  assign obj_ref_out = out_res.obj_ref_out;
  assign live_slots  = out_res.live_slots;

endmodule

// ===== tb/generational_handle_table_tb.sv =====
// ---------------------------------------------------------------------------
// Generational handle table testbench
// Drives register, unregister and resolve requests through the queue-style
// request port and compares every result beat against an in-bench slot map
// predictor. Runs a directed opening, then random phases under several
// capacity settings with random idling, a long result hold-off and a full
// drain in the middle of a phase.
// ---------------------------------------------------------------------------
module generational_handle_table_tb;
  import ght_pkg::*;

  localparam int SLOTS          = 1024;
  localparam int RAND_PER_PHASE = 103;
  localparam int PHASES         = 10;
  localparam int LONG_HOLD      = 200;  // cycles the receiver holds off once
  localparam int SETTLE         = 6;    // block latency plus margin
  localparam int MAX_REPORTS    = 10;
  localparam int RETIRED_KEEP   = 32;   // freed handles kept for stale reuse
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // How the driver fills in the handle of a beat when it goes on the bus:
  // from the live set, a live slot with a corrupted generation, or a freed one.
  typedef enum logic [1:0] {PICK_NONE, PICK_LIVE, PICK_STALE, PICK_DEAD} pick_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [OBJ_W-1:0] obj;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
    pick_t            pick;
  } req_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
  } handle_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_data;
  logic              push;
  logic              full;
  logic [REQ_W-1:0]  req_type;
  logic [OBJ_W-1:0]  obj_ref;
  logic [ID_W-1:0]   handle_id;
  logic [GEN_W-1:0]  handle_gen;
  logic              empty;
  logic              pop;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_id;
  logic [GEN_W-1:0]  out_gen;
  logic [OBJ_W-1:0]  obj_ref_out;
  logic [LIVE_W-1:0] live_slots;

  generational_handle_table #(.SLOTS(SLOTS)) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .obj_ref     (obj_ref),
    .handle_id   (handle_id),
    .handle_gen  (handle_gen),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .out_id      (out_id),
    .out_gen     (out_gen),
    .obj_ref_out (obj_ref_out),
    .live_slots  (live_slots)
  );

  // Slot map mirror: object, generation and free-list link per slot.
  logic [OBJ_W-1:0] slot_ref  [SLOTS];
  logic [GEN_W-1:0] slot_gen  [SLOTS];
  int unsigned      slot_next [SLOTS];
  int unsigned      avail_head;
  int unsigned      occupied;
  int unsigned      capacity;
  int unsigned      live_slot_q [$];   // indexes of occupied slots
  handle_t          retired_q [$];     // handles freed by unregister

  req_beat_t   pending_reqs [$];       // filled by the sequence, eaten by the driver
  res_t        want_results [$];       // one per accepted request, oldest first

  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned cfg_writes   = 0;
  int unsigned full_cycles  = 0;
  int unsigned status_tally [5] = '{0, 0, 0, 0, 0};

  bit          beat_taken       = 1'b0;
  bit          sender_idle_on   = 1'b1;
  bit          receiver_idle_on = 1'b1;
  int unsigned send_gap         = 0;
  int unsigned pop_gap          = 0;
  int unsigned hold_asks        = 0;
  int unsigned hold_served      = 0;
  req_beat_t   next_req;
  res_t        predicted;
  res_t        oldest;

  int unsigned phase_cap [PHASES] = '{2047, 1, 4, 2, 64, 1024, 7, 3, 16, 1};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Capacity write or reset: every slot empty at generation 1, links i+1.
  function automatic void rebuild_table(input int unsigned cap);
    capacity = cap;
    for (int i = 0; i < SLOTS; i++) begin
      slot_ref[i]  = '0;
      slot_gen[i]  = GEN_W'(1);
      slot_next[i] = i + 1;
    end
    avail_head = 0;
    occupied   = 0;
    live_slot_q.delete();
    retired_q.delete();
  endfunction

  // Handle match shared by unregister and resolve.
  function automatic logic [STAT_W-1:0] find_slot(input logic [ID_W-1:0] id,
                                                  input logic [GEN_W-1:0] gen,
                                                  output int unsigned idx);
    int unsigned i;
    idx = 0;
    if (id == '0 || gen == '0) return ST_INVALID;
    i = int'(id) - 1;
    if (i >= capacity) return ST_NOT_FOUND;
    if (slot_ref[i] == '0 || slot_gen[i] != gen) return ST_NOT_FOUND;
    idx = i;
    return ST_OK;
  endfunction

  function automatic res_t predict_request(input logic [REQ_W-1:0] rq,
                                           input logic [OBJ_W-1:0] obj,
                                           input logic [ID_W-1:0]  id,
                                           input logic [GEN_W-1:0] gen);
    res_t        r;
    int unsigned i;
    r = '0;
    r.status = ST_INVALID;
    case (rq)
      REQ_REGISTER: begin
        if (obj == '0) r.status = ST_INVALID;
        else if (id != '0 && gen != '0) r.status = ST_STATE;   // already holds a handle
        else if (avail_head >= capacity) r.status = ST_BUSY;   // free list exhausted
        else begin
          i = avail_head;
          avail_head = slot_next[i];
          slot_ref[i] = obj;
          r.out_id = ID_W'(i + 1);
          r.out_gen = slot_gen[i];
          occupied++;
          live_slot_q.push_back(i);
          r.status = ST_OK;
        end
      end
      REQ_UNREGISTER: begin
        r.status = find_slot(id, gen, i);
        if (r.status == ST_OK) begin
          if (occupied == 0) r.status = ST_STATE;
          else begin
            retired_q.push_back(handle_t'{id, gen});
            if (retired_q.size() > RETIRED_KEEP) void'(retired_q.pop_front());
            slot_ref[i] = '0;
            slot_gen[i] = slot_gen[i] + GEN_W'(1);
            if (slot_gen[i] == '0) slot_gen[i] = GEN_W'(1);  // never wraps to zero
            slot_next[i] = avail_head;
            avail_head = i;
            occupied--;
            foreach (live_slot_q[k]) begin
              if (live_slot_q[k] == i) begin
                live_slot_q.delete(k);
                break;
              end
            end
          end
        end
      end
      REQ_RESOLVE: begin
        r.status = find_slot(id, gen, i);
        if (r.status == ST_OK) r.obj_ref_out = slot_ref[i];
      end
      default: r.status = ST_INVALID;
    endcase
    r.live_slots = LIVE_W'(occupied);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, otherwise a short one, now and then a long one.
  function automatic int unsigned pick_gap(input bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OBJ_W-1:0] rand_ref();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    return $urandom;
  endfunction

  function automatic req_beat_t beat_of(input logic [REQ_W-1:0] rq,
                                        input logic [OBJ_W-1:0] obj,
                                        input logic [ID_W-1:0]  id,
                                        input logic [GEN_W-1:0] gen);
    return req_beat_t'{rq, obj, id, gen, PICK_NONE};
  endfunction

  // Mostly well-formed traffic against handles that exist, plus noise.
  function automatic req_beat_t random_beat();
    req_beat_t   b;
    int unsigned r;
    int unsigned m;
    b = beat_of(REQ_REGISTER, rand_ref(), '0, '0);
    r = $urandom_range(0, 99);
    m = $urandom_range(0, 99);
    if (r < 40) begin
      // register: usually presents no handle; sometimes a live one
      if (m < 60) ;
      else if (m < 75) b.gen = $urandom;
      else if (m < 85) b.id = ID_W'($urandom);
      else if (m < 95) b.pick = PICK_LIVE;
      else begin
        b.id  = ID_W'($urandom);
        b.gen = $urandom;
      end
    end else if (r < 95) begin
      b.req = (r < 65) ? REQ_UNREGISTER : REQ_RESOLVE;
      if (m < 60) b.pick = PICK_LIVE;
      else if (m < 72) b.pick = PICK_STALE;
      else if (m < 82) b.pick = PICK_DEAD;
      else begin
        b.id  = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 70)) : ID_W'($urandom);
        b.gen = $urandom_range(0, 1) ? GEN_W'($urandom_range(0, 3)) : GEN_W'($urandom);
      end
    end else begin
      b.req = REQ_W'($urandom_range(0, 3));
      b.id  = ID_W'($urandom);
      b.gen = $urandom;
    end
    return b;
  endfunction

  // Fill in the handle from the predictor state as it stands right now,
  // i.e. after every earlier request has been accepted.
  function automatic req_beat_t apply_pick(input req_beat_t b);
    int unsigned k;
    handle_t     h;
    case (b.pick)
      PICK_LIVE, PICK_STALE: begin
        if (live_slot_q.size() != 0) begin
          k = live_slot_q[$urandom_range(0, live_slot_q.size() - 1)];
          b.id  = ID_W'(k + 1);
          b.gen = slot_gen[k];
          if (b.pick == PICK_STALE) b.gen = b.gen ^ (32'h1 << $urandom_range(0, 31));
        end
      end
      PICK_DEAD: begin
        if (retired_q.size() != 0) begin
          h = retired_q[$urandom_range(0, retired_q.size() - 1)];
          b.id  = h.id;
          b.gen = h.gen;
        end
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic queue_beat(input req_beat_t b);
    pending_reqs.push_back(b);
    items_queued++;
  endtask

  // Block until every queued request has its result, then let the pipe settle.
  task automatic wait_idle();
    while (results_seen != items_queued) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_capacity(input logic [CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_writes++;
  endtask

  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: config, result check, request acceptance.
  // The check runs before acceptance so a fresh expectation can never be
  // matched by an unrequested result beat in the same cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rebuild_table(SLOTS);
      beat_taken <= 1'b0;
    end else begin
      // zero is ignored, anything above the slot count saturates
      if (cfg_we && cfg_data != '0) rebuild_table((cfg_data > SLOTS) ? SLOTS : cfg_data);

      if (!empty && pop) begin
        if (want_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result beat with nothing outstanding, status %0d",
                     $time, status);
        end else begin
          oldest = want_results.pop_front();
          results_seen++;
          if (oldest.status !== status) report_field("status", oldest.status, status);
          if (oldest.out_id !== out_id) report_field("out_id", oldest.out_id, out_id);
          if (oldest.out_gen !== out_gen) report_field("out_gen", oldest.out_gen, out_gen);
          if (oldest.obj_ref_out !== obj_ref_out)
            report_field("obj_ref_out", oldest.obj_ref_out, obj_ref_out);
          if (oldest.live_slots !== live_slots)
            report_field("live_slots", oldest.live_slots, live_slots);
        end
      end

      if (push && full) full_cycles++;
      beat_taken <= push && !full;
      if (push && !full) begin
        predicted = predict_request(req_type, obj_ref, handle_id, handle_gen);
        want_results.push_back(predicted);
        status_tally[predicted.status]++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: holds a beat until accepted, then idles or loads the next.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || beat_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req   = apply_pick(pending_reqs.pop_front());
        req_type   <= next_req.req;
        obj_ref    <= next_req.obj;
        handle_id  <= next_req.id;
        handle_gen <= next_req.gen;
        push       <= 1'b1;
        send_gap   = pick_gap(sender_idle_on);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random pop stalls, plus a long hold-off on request that
  // it counts out itself so the block backs up into its input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      pop_gap     = LONG_HOLD;
      pop <= 1'b0;
    end else if (pop_gap != 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      pop_gap = pick_gap(receiver_idle_on);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    push       = 1'b0;
    pop        = 1'b0;
    req_type   = REQ_REGISTER;
    obj_ref    = '0;
    handle_id  = '0;
    handle_gen = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening at the reset capacity. Ids follow the free list:
    // first register lands in id 1, second in id 2.
    queue_beat(beat_of(REQ_REGISTER, '0, '0, '0));             // null object
    queue_beat(beat_of(REQ_REGISTER, '1, '0, '0));             // id 1 gen 1
    queue_beat(beat_of(REQ_REGISTER, 32'h1, '1, '1));          // already has a handle
    queue_beat(beat_of(REQ_REGISTER, 32'h12345678, 16'd5, '0)); // id without gen is no handle
    queue_beat(beat_of(REQ_RESOLVE, '0, 16'd1, 32'd1));
    queue_beat(beat_of(REQ_RESOLVE, '0, '0, 32'd1));           // zero id
    queue_beat(beat_of(REQ_RESOLVE, '0, 16'd1, '0));           // zero generation
    queue_beat(beat_of(REQ_RESOLVE, '0, '1, 32'd1));           // id past capacity
    queue_beat(beat_of(REQ_RESOLVE, '0, 16'd1024, 32'd1));     // last slot, empty
    queue_beat(beat_of(REQ_RESOLVE, '0, 16'd1, 32'd2));        // generation mismatch
    queue_beat(beat_of(REQ_UNREGISTER, '0, 16'd1, 32'd1));
    queue_beat(beat_of(REQ_UNREGISTER, '0, 16'd1, 32'd1));     // already gone
    queue_beat(beat_of(REQ_RESOLVE, '0, 16'd1, 32'd1));        // stale handle
    queue_beat(beat_of(REQ_REGISTER, 32'h5, '0, '0));          // reuses id 1 at gen 2
    queue_beat(beat_of(REQ_UNREGISTER, '0, '0, '0));
    queue_beat(beat_of(REQ_UNKNOWN, '1, '1, '1));
    queue_beat(beat_of(REQ_UNREGISTER, '0, 16'd2, 32'd1));
    wait_idle();

    // A zero capacity write must leave the table alone.
    write_capacity('0);
    queue_beat(beat_of(REQ_RESOLVE, '0, 16'd1, 32'd2));
    wait_idle();

    // Single slot: second register finds the free list empty.
    write_capacity(11'd1);
    queue_beat(beat_of(REQ_REGISTER, 32'hA5A5A5A5, '0, '0));
    queue_beat(beat_of(REQ_REGISTER, 32'h5A5A5A5A, '0, '0));
    queue_beat(beat_of(REQ_RESOLVE, '0, 16'd2, 32'd1));
    queue_beat(beat_of(REQ_UNREGISTER, '0, 16'd1, 32'd1));
    queue_beat(beat_of(REQ_REGISTER, 32'h0000FFFF, '0, '0));
    wait_idle();

    // Random phases, one capacity setting each.
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(CFG_W'(phase_cap[p]));
      sender_idle_on   = ($urandom_range(0, 3) != 0);
      receiver_idle_on = ($urandom_range(0, 3) != 0);
      if (p == 4) begin
        // back the block up: receiver holds off, sender pushes flat out
        sender_idle_on = 1'b0;
        hold_asks++;
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        queue_beat(random_beat());
        if (p == 6 && n == RAND_PER_PHASE / 2) wait_idle();  // sender pause mid-phase
      end
      wait_idle();
    end

    errors += want_results.size();  // anything never delivered
    $display("Covered %0d requests over %0d capacity writes: %0d ok, %0d invalid,",
             results_seen, cfg_writes, status_tally[ST_OK], status_tally[ST_INVALID]);
    $display("  %0d wrong state, %0d not found, %0d busy; input held by full %0d cycles",
             status_tally[ST_STATE], status_tally[ST_NOT_FOUND], status_tally[ST_BUSY],
             full_cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every beat taking the longest
  // sender gap and pop stall).
  initial begin
    #5_000_000;
    $display("%0t: run timed out", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
